### rtl/core/crt_pkg.sv
// Package for the column run tracker: shared widths, register indexes,
// state and command types, and the saturating counter helper.
// No dependencies.
package crt_pkg;

    localparam int LABEL_W   = 16;
    localparam int FRAMES_W  = 16;
    localparam int COLUMN_W  = 16;
    localparam int TOL_W     = 12;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 16;

    // Result kinds.
    localparam logic KIND_RUN = 1'b0;
    localparam logic KIND_END = 1'b1;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DOWN_TOL   = 4'd0,
        REG_MIN_FRAMES = 4'd1
    } crt_reg_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_EV,
        S_CLOSE_WR,
        S_P1_RD,
        S_P1_EV,
        S_P2_RD,
        S_P2_EV,
        S_P3_RD,
        S_P3_EV,
        S_FLUSH
    } crt_state_t;

    // Commands to the claim table.
    typedef struct packed {
        logic take;
        logic release_old;
        logic clear;
    } claim_cmd_t;

    // Commands to the output stage and its status.
    typedef struct packed {
        logic push;
        logic flush;
    } out_cmd_t;

    typedef struct packed {
        logic can_push;
        logic hold_valid;
    } out_stat_t;

    function automatic logic [15:0] sat16_inc(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

endpackage

### rtl/core/crt_pix_if.sv
// Pixel input channel of the column run tracker.
// Depends on nothing.
interface crt_pix_if;
    logic valid;
    logic ready;
    logic pixel;
    logic column_end;
    logic image_end;

    modport source (output valid, pixel, column_end, image_end, input ready);
    modport sink   (input valid, pixel, column_end, image_end, output ready);
endinterface

### rtl/core/crt_res_if.sv
// Result output channel of the column run tracker.
// Depends on crt_pkg for field widths.
interface crt_res_if #(
    parameter int ROW_BITS = 12
);
    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic [crt_pkg::LABEL_W-1:0]   label;
    logic [ROW_BITS-1:0]           top;
    logic [ROW_BITS-1:0]           bottom;
    logic [crt_pkg::COLUMN_W-1:0]  column;
    logic [crt_pkg::FRAMES_W-1:0]  frames;
    logic                          last;

    modport source (output valid, kind, label, top, bottom, column, frames, last,
                    input ready);
    modport sink   (input valid, kind, label, top, bottom, column, frames, last,
                    output ready);
endinterface

### rtl/core/crt_cfg_if.sv
// Configuration write channel of the column run tracker.
// Depends on crt_pkg for index and data widths.
interface crt_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [crt_pkg::CFG_IDX_W-1:0]  index;
    logic [crt_pkg::CFG_DAT_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/crt_claims.sv
// Claim table: for each run of the previous column, whether a run of the
// current column holds it, which one, and at what distance. Uses crt_pkg.
module crt_claims #(
    parameter int MAX_RUNS = 16,
    parameter int ROW_BITS = 12,
    parameter int IDX_W    = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  crt_pkg::claim_cmd_t           cmd,
    input  logic [IDX_W-1:0]              set_idx,
    input  logic [IDX_W-1:0]              set_owner,
    input  logic [ROW_BITS-1:0]           set_dist,
    input  logic [IDX_W-1:0]              rel_idx,
    input  logic [IDX_W-1:0]              q_idx,
    output logic                          q_used,
    output logic [IDX_W-1:0]              q_owner,
    output logic [ROW_BITS-1:0]           q_dist
);
    import crt_pkg::*;

    logic                used_reg  [MAX_RUNS];
    logic [IDX_W-1:0]    owner_reg [MAX_RUNS];
    logic [ROW_BITS-1:0] dist_reg  [MAX_RUNS];

    // Claimed flags: cleared at once at column end.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int e = 0; e < MAX_RUNS; e++)
            begin
                used_reg[e] <= 1'b0;
            end
        end
        else
        begin
            for (int e = 0; e < MAX_RUNS; e++)
            begin
                if (cmd.clear)
                begin
                    used_reg[e] <= 1'b0;
                end
                else if (cmd.take && set_idx == IDX_W'(e))
                begin
                    used_reg[e] <= 1'b1;
                end
                else if (cmd.release_old && rel_idx == IDX_W'(e))
                begin
                    used_reg[e] <= 1'b0;
                end
            end
        end
    end

    // Owner and distance of each claim.
    always_ff @(posedge clk)
    begin
        for (int e = 0; e < MAX_RUNS; e++)
        begin
            if (cmd.take && set_idx == IDX_W'(e))
            begin
                owner_reg[e] <= set_owner;
                dist_reg[e]  <= set_dist;
            end
        end
    end

    assign q_used  = used_reg[q_idx];
    assign q_owner = owner_reg[q_idx];
    assign q_dist  = dist_reg[q_idx];

endmodule

### rtl/core/crt_out_stage.sv
// Output stage: a hold register that keeps the newest result back until it
// is known whether it is the last of its column, then the output register.
// Uses crt_pkg and the result channel interface.
module crt_out_stage #(
    parameter int ROW_BITS = 12
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  crt_pkg::out_cmd_t               cmd,
    output crt_pkg::out_stat_t              stat,
    input  logic                            cand_kind,
    input  logic [crt_pkg::LABEL_W-1:0]     cand_label,
    input  logic [ROW_BITS-1:0]             cand_top,
    input  logic [ROW_BITS-1:0]             cand_bottom,
    input  logic [crt_pkg::COLUMN_W-1:0]    cand_column,
    input  logic [crt_pkg::FRAMES_W-1:0]    cand_frames,
    crt_res_if.source                       results
);
    import crt_pkg::*;

    logic                 hold_valid_reg;
    logic                 out_valid_reg;
    logic                 hold_kind_reg;
    logic [LABEL_W-1:0]   hold_label_reg;
    logic [ROW_BITS-1:0]  hold_top_reg;
    logic [ROW_BITS-1:0]  hold_bottom_reg;
    logic [COLUMN_W-1:0]  hold_column_reg;
    logic [FRAMES_W-1:0]  hold_frames_reg;
    logic                 out_kind_reg;
    logic [LABEL_W-1:0]   out_label_reg;
    logic [ROW_BITS-1:0]  out_top_reg;
    logic [ROW_BITS-1:0]  out_bottom_reg;
    logic [COLUMN_W-1:0]  out_column_reg;
    logic [FRAMES_W-1:0]  out_frames_reg;
    logic                 out_last_reg;
    logic                 slot_free;
    logic                 do_push;
    logic                 do_flush;
    logic                 move_hold;

    assign slot_free = !out_valid_reg || results.ready;
    assign stat.can_push   = !hold_valid_reg || slot_free;
    assign stat.hold_valid = hold_valid_reg;
    assign do_push   = cmd.push && stat.can_push;
    assign do_flush  = cmd.flush && hold_valid_reg && slot_free;
    assign move_hold = (do_push && hold_valid_reg) || do_flush;

    // Valid flags of both registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (do_push)
            begin
                hold_valid_reg <= 1'b1;
            end
            else if (do_flush)
            begin
                hold_valid_reg <= 1'b0;
            end
            if (move_hold)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload: the hold register moves out, marked last only on a flush.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            hold_kind_reg   <= cand_kind;
            hold_label_reg  <= cand_label;
            hold_top_reg    <= cand_top;
            hold_bottom_reg <= cand_bottom;
            hold_column_reg <= cand_column;
            hold_frames_reg <= cand_frames;
        end
        if (move_hold)
        begin
            out_kind_reg   <= hold_kind_reg;
            out_label_reg  <= hold_label_reg;
            out_top_reg    <= hold_top_reg;
            out_bottom_reg <= hold_bottom_reg;
            out_column_reg <= hold_column_reg;
            out_frames_reg <= hold_frames_reg;
            out_last_reg   <= do_flush;
        end
    end

    assign results.valid  = out_valid_reg;
    assign results.kind   = out_kind_reg;
    assign results.label  = out_label_reg;
    assign results.top    = out_top_reg;
    assign results.bottom = out_bottom_reg;
    assign results.column = out_column_reg;
    assign results.frames = out_frames_reg;
    assign results.last   = out_last_reg;

endmodule

### rtl/core/crt_core.sv
// Tracker core: row counting, the match scan over the previous-run memory,
// the current-run memory and the column-end report passes.
// Uses crt_pkg, crt_claims, crt_out_stage and the channel interfaces.
module crt_core #(
    parameter int MAX_RUNS = 16,
    parameter int ROW_BITS = 12
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [crt_pkg::TOL_W-1:0]     down_tol,
    input  logic [crt_pkg::FRAMES_W-1:0]  min_frames,
    crt_pix_if.sink                       pixels,
    crt_res_if.source                     results
);
    import crt_pkg::*;

    localparam int CNT_W      = $clog2(MAX_RUNS + 1);
    localparam int IDX_W      = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;
    localparam int PREV_DEPTH = 2 * (1 << IDX_W);
    localparam int DW         = (ROW_BITS > TOL_W) ? ROW_BITS : TOL_W;

    typedef struct packed {
        logic [ROW_BITS-1:0] top;
        logic [ROW_BITS-1:0] bottom;
        logic [LABEL_W-1:0]  label;
        logic [FRAMES_W-1:0] frames;
    } run_ent_t;

    typedef struct packed {
        run_ent_t         run;
        logic [IDX_W-1:0] cidx;
        logic             has;
    } cur_ent_t;

    crt_state_t           state_reg, state_next;
    logic                 in_run_reg;
    logic [ROW_BITS-1:0]  row_reg;
    logic [ROW_BITS-1:0]  run_start_reg;
    logic [ROW_BITS-1:0]  close_top_reg;
    logic [ROW_BITS-1:0]  close_bot_reg;
    logic [COLUMN_W-1:0]  column_reg;
    logic [LABEL_W-1:0]   label_cnt_reg;
    logic [CNT_W-1:0]     prev_count_reg;
    logic [CNT_W-1:0]     cur_count_reg;
    logic [CNT_W-1:0]     idx_reg;
    logic                 bank_reg;
    logic                 best_valid_reg;
    logic [ROW_BITS-1:0]  best_reg;
    logic                 kr_has_reg;
    logic [IDX_W-1:0]     kr_idx_reg;
    logic [LABEL_W-1:0]   kr_label_reg;
    logic [FRAMES_W-1:0]  kr_frames_reg;
    logic                 col_end_reg;
    logic                 img_end_reg;

    run_ent_t             prev_mem [PREV_DEPTH];
    run_ent_t             prev_q;
    run_ent_t             prev_wd;
    logic [IDX_W:0]       prev_ra;
    logic [IDX_W:0]       prev_wa;
    logic                 prev_we;
    cur_ent_t             cur_mem [MAX_RUNS];
    cur_ent_t             cur_q;
    cur_ent_t             cur_wd;
    logic                 cur_we;

    logic                 acc;
    logic                 closing;
    logic                 moved_down;
    logic [ROW_BITS-1:0]  ad;
    logic                 take;
    logic                 used;
    logic [LABEL_W-1:0]   fresh_label;
    logic                 idx_clr;
    logic                 idx_inc;
    logic                 wrap;
    logic                 lbl_bump;
    claim_cmd_t           claim_cmd;
    logic [IDX_W-1:0]     q_idx;
    logic                 cl_used;
    logic [IDX_W-1:0]     cl_owner;
    logic [ROW_BITS-1:0]  cl_dist;
    out_cmd_t             out_cmd;
    out_stat_t            out_stat;
    logic                 cand_kind;
    logic [LABEL_W-1:0]   cand_label;
    logic [FRAMES_W-1:0]  cand_frames;
    logic [ROW_BITS-1:0]  cand_top;
    logic [ROW_BITS-1:0]  cand_bottom;

    assign pixels.ready = (state_reg == S_IDLE);
    assign acc          = pixels.valid && pixels.ready;
    assign closing      = in_run_reg && !pixels.pixel;

    // Distance between the closed run and the previous run being scanned.
    assign moved_down = close_top_reg > prev_q.top;
    assign ad = moved_down ? (close_top_reg - prev_q.top) : (prev_q.top - close_top_reg);
    assign take = !(moved_down && (DW'(ad) > DW'(down_tol)))
               && !(best_valid_reg && ad > best_reg)
               && (!cl_used || ad < cl_dist);

    // A current run keeps its match only if its claim was not taken away.
    assign used = cur_q.has && cl_used && (cl_owner == idx_reg[IDX_W-1:0]);
    assign fresh_label = sat16_inc(label_cnt_reg);

    // Memory addresses: the old bank holds the previous column's runs.
    assign prev_wa = {~bank_reg, idx_reg[IDX_W-1:0]};
    assign prev_wd = '{top: cur_q.run.top, bottom: cur_q.run.bottom,
                       label: cand_label, frames: cand_frames};
    assign cur_wd  = '{run: '{top: close_top_reg, bottom: close_bot_reg,
                              label: kr_label_reg, frames: kr_frames_reg},
                       cidx: kr_idx_reg, has: kr_has_reg};

    always_comb
    begin
        if (state_reg == S_P3_RD || state_reg == S_P3_EV)
        begin
            prev_ra = {~bank_reg, idx_reg[IDX_W-1:0]};
        end
        else
        begin
            prev_ra = {bank_reg, idx_reg[IDX_W-1:0]};
        end
    end

    // Previous-run memory, two banks, one read and one write port.
    always_ff @(posedge clk)
    begin
        if (prev_we)
        begin
            prev_mem[prev_wa] <= prev_wd;
        end
        prev_q <= prev_mem[prev_ra];
    end

    // Current-run memory.
    always_ff @(posedge clk)
    begin
        if (cur_we)
        begin
            cur_mem[cur_count_reg[IDX_W-1:0]] <= cur_wd;
        end
        cur_q <= cur_mem[idx_reg[IDX_W-1:0]];
    end

    // Candidate result: a current run in the first pass, else a stored run.
    always_comb
    begin
        if (state_reg == S_P1_EV)
        begin
            cand_kind   = KIND_RUN;
            cand_top    = cur_q.run.top;
            cand_bottom = cur_q.run.bottom;
            cand_label  = used ? cur_q.run.label : fresh_label;
            cand_frames = used ? cur_q.run.frames : '0;
        end
        else
        begin
            cand_kind   = KIND_END;
            cand_top    = prev_q.top;
            cand_bottom = prev_q.bottom;
            cand_label  = prev_q.label;
            cand_frames = prev_q.frames;
        end
    end

    // Sequencer: next state and strobes.
    always_comb
    begin
        state_next = state_reg;
        claim_cmd  = '0;
        out_cmd    = '0;
        q_idx      = idx_reg[IDX_W-1:0];
        prev_we    = 1'b0;
        cur_we     = 1'b0;
        idx_clr    = 1'b0;
        idx_inc    = 1'b0;
        wrap       = 1'b0;
        lbl_bump   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                idx_clr = acc;
                if (acc && closing && cur_count_reg < CNT_W'(MAX_RUNS))
                begin
                    state_next = (prev_count_reg != '0) ? S_SCAN_RD : S_CLOSE_WR;
                end
                else if (acc && pixels.column_end)
                begin
                    state_next = S_P1_RD;
                end
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN_EV;
            end
            S_SCAN_EV:
            begin
                claim_cmd.take        = take;
                claim_cmd.release_old = take && kr_has_reg;
                idx_inc = 1'b1;
                if (idx_reg + 1'b1 == prev_count_reg)
                begin
                    state_next = S_CLOSE_WR;
                end
                else
                begin
                    state_next = S_SCAN_RD;
                end
            end
            S_CLOSE_WR:
            begin
                cur_we  = 1'b1;
                idx_clr = 1'b1;
                state_next = col_end_reg ? S_P1_RD : S_IDLE;
            end
            S_P1_RD:
            begin
                if (idx_reg == cur_count_reg)
                begin
                    idx_clr    = 1'b1;
                    state_next = S_P2_RD;
                end
                else
                begin
                    state_next = S_P1_EV;
                end
            end
            S_P1_EV:
            begin
                q_idx        = cur_q.cidx;
                out_cmd.push = 1'b1;
                if (out_stat.can_push)
                begin
                    prev_we    = 1'b1;
                    lbl_bump   = !used;
                    idx_inc    = 1'b1;
                    state_next = S_P1_RD;
                end
            end
            S_P2_RD:
            begin
                if (idx_reg == prev_count_reg)
                begin
                    idx_clr    = 1'b1;
                    state_next = img_end_reg ? S_P3_RD : S_FLUSH;
                end
                else
                begin
                    state_next = S_P2_EV;
                end
            end
            S_P2_EV:
            begin
                out_cmd.push = !cl_used && (prev_q.frames > min_frames);
                if (!out_cmd.push || out_stat.can_push)
                begin
                    idx_inc    = 1'b1;
                    state_next = S_P2_RD;
                end
            end
            S_P3_RD:
            begin
                state_next = (idx_reg == cur_count_reg) ? S_FLUSH : S_P3_EV;
            end
            S_P3_EV:
            begin
                out_cmd.push = prev_q.frames > min_frames;
                if (!out_cmd.push || out_stat.can_push)
                begin
                    idx_inc    = 1'b1;
                    state_next = S_P3_RD;
                end
            end
            S_FLUSH:
            begin
                out_cmd.flush = 1'b1;
                if (!out_stat.hold_valid)
                begin
                    wrap            = 1'b1;
                    claim_cmd.clear = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_run_reg     <= 1'b0;
            row_reg        <= '0;
            run_start_reg  <= '0;
            column_reg     <= COLUMN_W'(1);
            label_cnt_reg  <= '0;
            prev_count_reg <= '0;
            cur_count_reg  <= '0;
            idx_reg        <= '0;
            bank_reg       <= 1'b0;
            best_valid_reg <= 1'b0;
            kr_has_reg     <= 1'b0;
            col_end_reg    <= 1'b0;
            img_end_reg    <= 1'b0;
        end
        else
        begin
            if (acc)
            begin
                col_end_reg    <= pixels.column_end;
                img_end_reg    <= pixels.column_end && pixels.image_end;
                kr_has_reg     <= 1'b0;
                best_valid_reg <= 1'b0;
                if (pixels.column_end)
                begin
                    in_run_reg    <= 1'b0;
                    row_reg       <= '0;
                    run_start_reg <= '0;
                end
                else
                begin
                    in_run_reg <= pixels.pixel;
                    if (!in_run_reg && pixels.pixel)
                    begin
                        run_start_reg <= row_reg;
                    end
                    if (row_reg != {ROW_BITS{1'b1}})
                    begin
                        row_reg <= row_reg + 1'b1;
                    end
                end
            end
            if (claim_cmd.take)
            begin
                best_valid_reg <= 1'b1;
                kr_has_reg     <= 1'b1;
            end
            if (idx_clr)
            begin
                idx_reg <= '0;
            end
            else if (idx_inc)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (cur_we)
            begin
                cur_count_reg <= cur_count_reg + 1'b1;
            end
            if (lbl_bump)
            begin
                label_cnt_reg <= fresh_label;
            end
            // Column wrap-up: the new bank becomes the previous column.
            if (wrap)
            begin
                bank_reg      <= ~bank_reg;
                cur_count_reg <= '0;
                if (img_end_reg)
                begin
                    prev_count_reg <= '0;
                    column_reg     <= COLUMN_W'(1);
                    label_cnt_reg  <= '0;
                end
                else
                begin
                    prev_count_reg <= cur_count_reg;
                    column_reg     <= sat16_inc(column_reg);
                end
            end
        end
    end

    // Closed run geometry and the best match found so far.
    always_ff @(posedge clk)
    begin
        if (acc && closing)
        begin
            close_top_reg <= run_start_reg;
            close_bot_reg <= row_reg;
        end
        if (claim_cmd.take)
        begin
            best_reg      <= ad;
            kr_idx_reg    <= idx_reg[IDX_W-1:0];
            kr_label_reg  <= prev_q.label;
            kr_frames_reg <= sat16_inc(prev_q.frames);
        end
    end

    crt_claims #(
        .MAX_RUNS (MAX_RUNS),
        .ROW_BITS (ROW_BITS),
        .IDX_W    (IDX_W)
    ) u_claims (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (claim_cmd),
        .set_idx   (idx_reg[IDX_W-1:0]),
        .set_owner (cur_count_reg[IDX_W-1:0]),
        .set_dist  (ad),
        .rel_idx   (kr_idx_reg),
        .q_idx     (q_idx),
        .q_used    (cl_used),
        .q_owner   (cl_owner),
        .q_dist    (cl_dist)
    );

    crt_out_stage #(
        .ROW_BITS (ROW_BITS)
    ) u_out_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (out_cmd),
        .stat        (out_stat),
        .cand_kind   (cand_kind),
        .cand_label  (cand_label),
        .cand_top    (cand_top),
        .cand_bottom (cand_bottom),
        .cand_column (column_reg),
        .cand_frames (cand_frames),
        .results     (results)
    );

endmodule

### rtl/core/column_run_tracker_top.sv
// Top level of the column run tracker: configuration registers and the core.
// Uses crt_pkg, crt_core and the channel interfaces.
//
//   channel  | dir | payload                                     | flow
//   pixels   | in  | pixel, column_end, image_end                | valid/ready
//   results  | out | kind, label, top, bottom, column, frames,last | valid/ready
//   cfg      | in  | index, data                                 | valid/ready
//
// A pixel beat that ends neither a run nor a column keeps the sequencer idle.
// A beat that ends a run starts the match scan, which reads the previous-run
// memory one entry per read and evaluate state pair. A column end adds the
// report passes (current runs, previous runs, and current runs again on the
// last column), which share that memory port.
// Reset needs no clearing pass; results stall the report passes only.
module column_run_tracker_top #(
    parameter int MAX_RUNS = 16,
    parameter int ROW_BITS = 12
) (
    input  logic       clk,
    input  logic       rst_n,
    crt_pix_if.sink    pixels,
    crt_res_if.source  results,
    crt_cfg_if.sink    cfg
);
    import crt_pkg::*;

    logic [TOL_W-1:0]    down_tol_reg;
    logic [FRAMES_W-1:0] min_frames_reg;

    assign cfg.ready = 1'b1;

    // Register writes; unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            down_tol_reg   <= TOL_W'(10);
            min_frames_reg <= FRAMES_W'(5);
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_DOWN_TOL:   down_tol_reg   <= cfg.data[TOL_W-1:0];
                REG_MIN_FRAMES: min_frames_reg <= cfg.data[FRAMES_W-1:0];
                default:        ;
            endcase
        end
    end

    crt_core #(
        .MAX_RUNS (MAX_RUNS),
        .ROW_BITS (ROW_BITS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .down_tol   (down_tol_reg),
        .min_frames (min_frames_reg),
        .pixels     (pixels),
        .results    (results)
    );

endmodule

### rtl/core/crt_checker.sv
// Port checker for the column run tracker and its bind to the top level.
// Uses crt_pkg for the result kinds.
module crt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        pix_ready,
    input logic        res_valid,
    input logic        res_ready,
    input logic        res_kind,
    input logic        res_last,
    input logic [15:0] res_label,
    input logic [15:0] res_frames
);
    import crt_pkg::*;

    // A result beat waits until it is taken.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result beat dropped while stalled");

    // No pixel is taken while a column's results are still going out.
    a_no_pix_mid_report: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_last |-> !pix_ready)
        else $error("pixel accepted during column report");

    // Every reported track carries a label.
    a_label_set: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_label != 16'd0)
        else $error("result with zero label");

    // An ended track has followed at least one column.
    a_end_frames: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_kind == KIND_END |-> res_frames != 16'd0)
        else $error("ended track with no frames");

endmodule

bind column_run_tracker_top crt_checker u_crt_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .pix_ready  (pixels.ready),
    .res_valid  (results.valid),
    .res_ready  (results.ready),
    .res_kind   (results.kind),
    .res_last   (results.last),
    .res_label  (results.label),
    .res_frames (results.frames)
);
